// ===== hdl/vca_pkg.sv =====
// ---------------------------------------------------------------------------
// vca_pkg: shared types and constants for the voice channel allocator
// Request and result structs, sequencer states, mode and class codes,
// and the fixed per-class channel preference lists.
// ---------------------------------------------------------------------------
package vca_pkg;

    localparam int unsigned NUM_CH = 16;
    localparam int unsigned CH_W   = 4;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned VOL_W  = 11;

    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_SET_PRIO = 2'd1;
    localparam logic [1:0] MODE_SET_VOL  = 2'd2;

    localparam logic [1:0] CLS_PCM     = 2'd0;
    localparam logic [1:0] CLS_PSG     = 2'd1;
    localparam logic [1:0] CLS_NOISE   = 2'd2;
    localparam logic [1:0] CLS_REFUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        chan_class;
        logic [PRIO_W-1:0] request_prio;
        logic [CH_W-1:0]   channel;
        logic [VOL_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic            granted;
        logic [CH_W-1:0] channel_no;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    localparam logic [CH_W-1:0] PCM_ORDER [16] = '{
        4'd4, 4'd5, 4'd6, 4'd7, 4'd2, 4'd0, 4'd3, 4'd1,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd14, 4'd12, 4'd15, 4'd13
    };
    localparam logic [CH_W-1:0] PSG_ORDER [8] = '{
        4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd0, 4'd0
    };
    localparam logic [CH_W-1:0] NOISE_ORDER [2] = '{4'd15, 4'd14};

    // channel at position idx of a class's preference list
    function automatic logic [CH_W-1:0] order_chan(input logic [1:0] cls,
                                                   input logic [CH_W-1:0] idx);
        logic [CH_W-1:0] ch;
        ch = '0;
        case (cls)
            CLS_PCM:   ch = PCM_ORDER[idx];
            CLS_PSG:   ch = PSG_ORDER[idx[2:0]];
            CLS_NOISE: ch = NOISE_ORDER[idx[0]];
            default:   ch = '0;
        endcase
        return ch;
    endfunction

    // last list position of a class (refused class never scans)
    function automatic logic [CH_W-1:0] class_last(input logic [1:0] cls);
        logic [CH_W-1:0] last;
        last = '0;
        case (cls)
            CLS_PCM:   last = 4'd15;
            CLS_PSG:   last = 4'd5;
            CLS_NOISE: last = 4'd1;
            default:   last = '0;
        endcase
        return last;
    endfunction

endpackage

// ===== hdl/voice_channel_allocator.sv =====
// ---------------------------------------------------------------------------
// voice_channel_allocator: priority-based voice stealing over 16 channels
// Walks a class's preference list through one shared compare unit, keeps
// the lowest-priority / lowest-volume unlocked channel, grants it if the
// request priority is high enough, and clears the winner's volume.
// ---------------------------------------------------------------------------
//  channel | dir | payload              | handshake
//  in      | in  | vca_pkg::in_item_t   | in_valid / in_ready
//  out     | out | vca_pkg::out_item_t  | out_valid / out_ready
//  cfg     | in  | lock_mask, 16 bits   | cfg_valid / cfg_ready (always ready)
//
//  An allocate request scans its class's preference list and then finishes;
//  updates, mode three and refused classes go straight to the finish step. The compare
//  unit visits one list entry per cycle. in_ready is high only while the
//  sequencer is idle, from the cycle after the result is loaded; a pending result
//  is held in the output register while the next request is taken, and a
//  full output register stalls the finish step. Reset clears priorities,
//  volumes, lock mask and control.
// ---------------------------------------------------------------------------
module voice_channel_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vca_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vca_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    vca_pkg::state_t state_reg, state_next;

    logic [vca_pkg::PRIO_W-1:0] prio_reg [vca_pkg::NUM_CH];
    logic [vca_pkg::VOL_W-1:0]  vol_reg  [vca_pkg::NUM_CH];
    logic [15:0]                lock_mask_reg;

    logic [1:0]                 mode_reg;
    logic [1:0]                 cls_reg;
    logic [vca_pkg::PRIO_W-1:0] req_reg;
    logic [vca_pkg::CH_W-1:0]   idx_reg, idx_next;
    logic                       found_reg, found_next;
    logic [vca_pkg::CH_W-1:0]   best_ch_reg, best_ch_next;
    logic [vca_pkg::PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [vca_pkg::VOL_W-1:0]  best_vol_reg, best_vol_next;

    logic                       out_valid_reg;
    vca_pkg::out_item_t         out_data_reg;

    logic                       accept;
    logic                       scan_en;
    logic                       finish_en;
    logic                       out_load;
    logic                       scan_last;
    logic                       grant;
    logic                       needs_scan;

    logic [vca_pkg::CH_W-1:0]   cand_ch;
    logic [vca_pkg::PRIO_W-1:0] cand_prio;
    logic [vca_pkg::VOL_W-1:0]  cand_vol;
    logic                       take;

    assign accept     = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign needs_scan = (in_data.mode == vca_pkg::MODE_ALLOC)
                        && (in_data.chan_class != vca_pkg::CLS_REFUSED);
    assign scan_last  = (idx_reg == vca_pkg::class_last(cls_reg));
    assign out_load   = finish_en && (!out_valid_reg || out_ready);
    assign grant      = (mode_reg == vca_pkg::MODE_ALLOC) && found_reg
                        && (req_reg >= best_prio_reg);

    // shared compare unit: one preference-list entry per cycle
    always_comb
    begin
        cand_ch   = vca_pkg::order_chan(cls_reg, idx_reg);
        cand_prio = prio_reg[cand_ch];
        cand_vol  = vol_reg[cand_ch];
        take      = !lock_mask_reg[cand_ch]
                    && (!found_reg || (cand_prio < best_prio_reg)
                        || ((cand_prio == best_prio_reg) && (cand_vol < best_vol_reg)));
    end

    always_comb
    begin
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_ch_next   = best_ch_reg;
        best_prio_next = best_prio_reg;
        best_vol_next  = best_vol_reg;
        if (accept)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        else if (scan_en)
        begin
            idx_next = idx_reg + {{(vca_pkg::CH_W-1){1'b0}}, 1'b1};
            if (take)
            begin
                found_next     = 1'b1;
                best_ch_next   = cand_ch;
                best_prio_next = cand_prio;
                best_vol_next  = cand_vol;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vca_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = needs_scan ? vca_pkg::ST_SCAN : vca_pkg::ST_FINISH;
            end
            vca_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = vca_pkg::ST_FINISH;
            end
            vca_pkg::ST_FINISH:
            begin
                if (out_load)
                    state_next = vca_pkg::ST_IDLE;
            end
            default: state_next = vca_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        scan_en   = 1'b0;
        finish_en = 1'b0;
        case (state_reg)
            vca_pkg::ST_IDLE:   in_ready  = 1'b1;
            vca_pkg::ST_SCAN:   scan_en   = 1'b1;
            vca_pkg::ST_FINISH: finish_en = 1'b1;
            default:            in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vca_pkg::ST_IDLE;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            lock_mask_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
                lock_mask_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        best_ch_reg   <= best_ch_next;
        best_prio_reg <= best_prio_next;
        best_vol_reg  <= best_vol_next;
        if (accept)
        begin
            mode_reg <= in_data.mode;
            cls_reg  <= in_data.chan_class;
            req_reg  <= in_data.request_prio;
        end
        if (out_load)
        begin
            out_data_reg.granted    <= grant;
            out_data_reg.channel_no <= grant ? best_ch_reg : '0;
        end
    end

    // channel state; updates land at accept, the steal clear at finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vca_pkg::NUM_CH; i++)
            begin
                prio_reg[i] <= '0;
                vol_reg[i]  <= '0;
            end
        end
        else
        begin
            if (accept && (in_data.mode == vca_pkg::MODE_SET_PRIO))
                prio_reg[in_data.channel] <= in_data.value[vca_pkg::PRIO_W-1:0];
            if (accept && (in_data.mode == vca_pkg::MODE_SET_VOL))
                vol_reg[in_data.channel] <= in_data.value;
            else if (out_load && grant)
                vol_reg[best_ch_reg] <= '0;
        end
    end

    a_alloc_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept && needs_scan |=> state_reg == vca_pkg::ST_SCAN)
        else $error("allocate request did not start a scan");

    a_scan_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vca_pkg::ST_SCAN |->
            (mode_reg == vca_pkg::MODE_ALLOC) && (cls_reg != vca_pkg::CLS_REFUSED))
        else $error("scan running for a non-allocate item");

    a_best_prio_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != vca_pkg::ST_IDLE) && found_reg |->
            prio_reg[best_ch_reg] == best_prio_reg)
        else $error("held best priority disagrees with channel table");

    a_best_vol_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vca_pkg::ST_SCAN) && found_reg |->
            vol_reg[best_ch_reg] == best_vol_reg)
        else $error("held best volume disagrees with channel table");

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for voice_channel_allocator
// A stimulus table covers reset behavior, field extremes, every mode and class,
// full locking and refusal by priority. Random requests follow under several
// lock masks and stall patterns. Every result is checked against a table value
// or a local model of the channel priorities and volumes.
// ---------------------------------------------------------------------------
module tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned LIMIT = 200000;
    localparam int unsigned SECTION_ITEMS = 117;

    // preference lists per class
    localparam logic [3:0] PCM_PREF [16] = '{
        4'd4, 4'd5, 4'd6, 4'd7, 4'd2, 4'd0, 4'd3, 4'd1,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd14, 4'd12, 4'd15, 4'd13
    };
    localparam logic [3:0] PSG_PREF [6] = '{4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8};
    localparam logic [3:0] NOISE_PREF [2] = '{4'd15, 4'd14};

    typedef struct {
        bit                 is_cfg;
        logic [15:0]        mask;
        vca_pkg::in_item_t  item;
        bit                 typed;
        vca_pkg::out_item_t want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    vca_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    vca_pkg::out_item_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;

    logic [7:0]  chan_prio [16];
    logic [10:0] chan_vol [16];
    logic [15:0] lock_bits;

    vca_pkg::out_item_t pending_grants [$];
    vca_pkg::out_item_t oldest_grant;
    plan_row_t          plan [$];

    int unsigned errors;
    int unsigned cycles;
    int unsigned tx_idle;
    int unsigned rx_idle;

    voice_channel_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // lowest priority, then strictly lower volume, first seen on a full tie
    function automatic int steal_pick(input logic [1:0] cls);
        int best;
        int len;
        logic [3:0] c;
        best = -1;
        len = (cls == vca_pkg::CLS_PCM) ? 16 : (cls == vca_pkg::CLS_PSG) ? 6
              : (cls == vca_pkg::CLS_NOISE) ? 2 : 0;
        for (int i = 0; i < len; i++)
        begin
            if (cls == vca_pkg::CLS_PCM)
                c = PCM_PREF[i];
            else if (cls == vca_pkg::CLS_PSG)
                c = PSG_PREF[i];
            else
                c = NOISE_PREF[i];
            if (!lock_bits[c])
            begin
                if (best < 0)
                    best = int'(c);
                else if (chan_prio[c] < chan_prio[best])
                    best = int'(c);
                else if (chan_prio[c] == chan_prio[best] && chan_vol[c] < chan_vol[best])
                    best = int'(c);
            end
        end
        return best;
    endfunction

    function automatic vca_pkg::out_item_t allocate_voice(input vca_pkg::in_item_t it);
        vca_pkg::out_item_t res;
        int win;
        res = '0;
        case (it.mode)
            vca_pkg::MODE_SET_PRIO: chan_prio[it.channel] = it.value[7:0];
            vca_pkg::MODE_SET_VOL:  chan_vol[it.channel] = it.value;
            vca_pkg::MODE_ALLOC:
            begin
                win = steal_pick(it.chan_class);
                if (win >= 0 && it.request_prio >= chan_prio[win])
                begin
                    chan_vol[win] = '0;
                    res.granted = 1'b1;
                    res.channel_no = win[3:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic vca_pkg::in_item_t make_req(input logic [1:0] mode,
                                                   input logic [1:0] cls,
                                                   input logic [7:0] req,
                                                   input logic [3:0] ch,
                                                   input logic [10:0] val);
        vca_pkg::in_item_t it;
        it.mode = mode;
        it.chan_class = cls;
        it.request_prio = req;
        it.channel = ch;
        it.value = val;
        return it;
    endfunction

    function automatic vca_pkg::in_item_t rand_req();
        int unsigned r;
        vca_pkg::in_item_t it;
        r = $urandom_range(0, 99);
        it = make_req(vca_pkg::MODE_ALLOC, 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      11'($urandom_range(0, 2047)));
        if (r < 45)
        begin
            it.chan_class = ($urandom_range(0, 9) == 0) ? vca_pkg::CLS_REFUSED
                            : 2'($urandom_range(0, 2));
            // low request priorities get refused often
            if ($urandom_range(0, 1))
                it.request_prio = 8'($urandom_range(0, 15));
        end
        else if (r < 70)
        begin
            it.mode = vca_pkg::MODE_SET_PRIO;
            if ($urandom_range(0, 1))
                it.value = 11'($urandom_range(0, 15));
        end
        else if (r < 95)
        begin
            it.mode = vca_pkg::MODE_SET_VOL;
            if ($urandom_range(0, 1))
                it.value = 11'($urandom_range(0, 3));
        end
        else
            it.mode = MODE_UNUSED;
        return it;
    endfunction

    task automatic add_req(input vca_pkg::in_item_t it, input bit typed, input logic granted,
                           input logic [3:0] ch);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.mask = '0;
        row.item = it;
        row.typed = typed;
        row.want.granted = granted;
        row.want.channel_no = ch;
        plan.push_back(row);
    endtask

    task automatic add_cfg(input logic [15:0] mask);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.mask = mask;
        plan.push_back(row);
    endtask

    task automatic wait_all_granted();
        while (pending_grants.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_lock_mask(input logic [15:0] mask);
        in_valid = 1'b0;
        wait_all_granted();
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = mask;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        lock_bits = mask;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // enters and leaves at a falling edge
    task automatic send_request(input vca_pkg::in_item_t it, input bit typed,
                                input vca_pkg::out_item_t want);
        vca_pkg::out_item_t pred;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = allocate_voice(it);
        pending_grants.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_ready <= (rx_idle == 0) || ($urandom_range(0, 99) >= rx_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_grants.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
            end
            else
            begin
                oldest_grant = pending_grants.pop_front();
                if (out_data.granted !== oldest_grant.granted)
                begin
                    errors++;
                    $display("%0t: granted mismatch, expected %b, actual %b", $time,
                             oldest_grant.granted, out_data.granted);
                end
                if (out_data.channel_no !== oldest_grant.channel_no)
                begin
                    errors++;
                    $display("%0t: channel_no mismatch, expected %0d, actual %0d", $time,
                             oldest_grant.channel_no, out_data.channel_no);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] mask;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        tx_idle = 10;
        rx_idle = 46;
        lock_bits = '0;
        for (int i = 0; i < 16; i++)
        begin
            chan_prio[i] = '0;
            chan_vol[i] = '0;
        end

        // after reset every channel ties, so the first list entry wins
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PCM, 8'd0, 4'd0, 11'd0),
                1, 1'b1, 4'd4);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PSG, 8'd0, 4'd15, 11'd2047),
                1, 1'b1, 4'd13);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_NOISE, 8'd0, 4'd0, 11'd0),
                1, 1'b1, 4'd15);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_REFUSED, 8'd255, 4'd15, 11'd2047),
                1, 1'b0, 4'd0);
        add_req(make_req(MODE_UNUSED, vca_pkg::CLS_PCM, 8'd255, 4'd15, 11'd2047),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_SET_PRIO, vca_pkg::CLS_REFUSED, 8'd255, 4'd4, 11'd2047),
                1, 1'b0, 4'd0);
        // only the low 8 bits land, so channel 0 keeps priority zero
        add_req(make_req(vca_pkg::MODE_SET_PRIO, vca_pkg::CLS_PCM, 8'd0, 4'd0, 11'h100),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_SET_VOL, vca_pkg::CLS_PCM, 8'd0, 4'd5, 11'd2047),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_SET_VOL, vca_pkg::CLS_PCM, 8'd0, 4'd6, 11'd0),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PCM, 8'd255, 4'd0, 11'd0),
                0, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PCM, 8'd0, 4'd0, 11'd0),
                0, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_SET_PRIO, vca_pkg::CLS_PCM, 8'd0, 4'd15, 11'd9),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_SET_PRIO, vca_pkg::CLS_PCM, 8'd0, 4'd14, 11'd9),
                1, 1'b0, 4'd0);
        // request below the winner's priority
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_NOISE, 8'd8, 4'd0, 11'd0),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_NOISE, 8'd9, 4'd0, 11'd0),
                0, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_SET_VOL, vca_pkg::CLS_PCM, 8'd0, 4'd13, 11'd1),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_SET_PRIO, vca_pkg::CLS_PCM, 8'd0, 4'd8, 11'd255),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PSG, 8'd0, 4'd0, 11'd0),
                0, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PSG, 8'd254, 4'd0, 11'd0),
                0, 1'b0, 4'd0);
        // everything locked: no candidate in any class
        add_cfg(16'hFFFF);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PCM, 8'd255, 4'd0, 11'd0),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PSG, 8'd255, 4'd0, 11'd0),
                1, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_NOISE, 8'd255, 4'd0, 11'd0),
                1, 1'b0, 4'd0);
        add_cfg(16'h7FFF);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_NOISE, 8'd255, 4'd0, 11'd0),
                0, 1'b0, 4'd0);
        add_req(make_req(vca_pkg::MODE_ALLOC, vca_pkg::CLS_PCM, 8'd255, 4'd0, 11'd0),
                0, 1'b0, 4'd0);

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_lock_mask(plan[i].mask);
            else
                send_request(plan[i].item, plan[i].typed, plan[i].want);
        end
        in_valid = 1'b0;

        for (int sec = 0; sec < 6; sec++)
        begin
            case (sec / 2)
                0:       begin tx_idle = 10; rx_idle = 46; end
                1:       begin tx_idle = 46; rx_idle = 10; end
                default: begin tx_idle = 0;  rx_idle = 0;  end
            endcase
            case (sec)
                0:       mask = 16'h0000;
                2:       mask = 16'hFFFF;
                4:       mask = 16'h3FFF;
                3:       mask = 16'($urandom_range(0, 16'hFFFF));
                default: mask = 16'($urandom_range(0, 16'hFFFF) & $urandom_range(0, 16'hFFFF));
            endcase
            write_lock_mask(mask);
            for (int k = 0; k < SECTION_ITEMS; k++)
            begin
                // hold off until every pending request has its result
                if (sec == 0 && k == SECTION_ITEMS / 2)
                begin
                    in_valid = 1'b0;
                    wait_all_granted();
                end
                send_request(rand_req(), 0, '0);
            end
            in_valid = 1'b0;
        end

        wait_all_granted();
        repeat (25) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
